FILE: src/sls_pkg.sv
// ----------------------------------------------------------------------------
// sls_pkg
// Shared types and constants for the searchable LIFO stack core.
// ----------------------------------------------------------------------------
package sls_pkg;

	localparam int DATA_W        = 32;
	localparam int COUNT_W       = 5;
	localparam int DEFAULT_DEPTH = 16;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_SEARCH = 2'd2,
		OP_UPDATE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [DATA_W-1:0]  value;
		logic signed [DATA_W-1:0]  new_value;
	} in_word_t;

	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  data_out;
		logic signed [DATA_W-1:0]  top_value;
		logic                      is_empty;
		logic [COUNT_W-1:0]        element_count;
	} out_word_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
		logic upd;
	} cell_ctrl_t;

endpackage

FILE: src/sls_cell.sv
// ----------------------------------------------------------------------------
// sls_cell
// One stack slot. Shifts down on push, up on pop, compares against the key
// and, on an update, rewrites itself when it holds the match nearest the top.
// ----------------------------------------------------------------------------
module sls_cell (
	input  logic                              clk,
	input  sls_pkg::cell_ctrl_t               ctrl,
	input  logic                              occupied,
	input  logic signed [sls_pkg::DATA_W-1:0] key,
	input  logic signed [sls_pkg::DATA_W-1:0] new_value,
	input  logic signed [sls_pkg::DATA_W-1:0] above,
	input  logic signed [sls_pkg::DATA_W-1:0] below,
	input  logic                              match_in,
	output logic                              match_out,
	output logic                              first_hit,
	output logic signed [sls_pkg::DATA_W-1:0] data
);

	logic signed [sls_pkg::DATA_W-1:0] data_q;
	logic                              hit;

	assign hit       = occupied && (data_q == key);
	assign first_hit = hit && !match_in;
	assign match_out = match_in || hit;
	assign data      = data_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			data_q <= above;
		end else if (ctrl.pop) begin
			data_q <= below;
		end else if (ctrl.upd && first_hit) begin
			data_q <= new_value;
		end
	end

endmodule

FILE: src/searchable_lifo_stack_core.sv
// ----------------------------------------------------------------------------
// searchable_lifo_stack_core
// Bounded LIFO stack of signed 32-bit words with push, pop, search and
// update-first-match, built as a row of shifting, comparing cells.
// ----------------------------------------------------------------------------
// Takes one command word per clock: busy stays low, so start may be held high
// every cycle. Each command's result word appears on result, with strobe high,
// in the cycle after the command is taken and for that one cycle only;
// the receiver must capture it then. All DEPTH cells compare against the key
// in the same cycle, and the nearest-to-top match is picked by a priority
// chain running through the cells, whose length (DEPTH) sets the clock limit.
// Entries need no clearing after reset; the stack starts empty.
module searchable_lifo_stack_core #(
	parameter int DEPTH = sls_pkg::DEFAULT_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sls_pkg::in_word_t cmd,
	output logic              strobe,
	output sls_pkg::out_word_t result
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  count_next;
	logic                              strobe_q;
	sls_pkg::out_word_t                result_q;
	sls_pkg::out_word_t                result_next;
	sls_pkg::cell_ctrl_t               ctrl;

	logic signed [sls_pkg::DATA_W-1:0] cell_data  [DEPTH];
	logic signed [sls_pkg::DATA_W-1:0] cell_above [DEPTH];
	logic signed [sls_pkg::DATA_W-1:0] cell_below [DEPTH];
	logic                              cell_hit1  [DEPTH];
	logic                              match      [DEPTH+1];

	logic is_push, is_pop, is_upd;
	logic empty, full, found;

	assign busy   = 1'b0;
	assign strobe = strobe_q;
	assign result = result_q;

	assign is_push   = start && (cmd.kind == sls_pkg::OP_PUSH);
	assign is_pop    = start && (cmd.kind == sls_pkg::OP_POP);
	assign is_upd    = start && (cmd.kind == sls_pkg::OP_UPDATE);

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));

	assign ctrl.push = is_push && !full;
	assign ctrl.pop  = is_pop && !empty;
	assign ctrl.upd  = is_upd;

	assign match[0] = 1'b0;
	assign found    = match[DEPTH];

	// cell 0 is the top of the stack
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_top
				assign cell_above[gi] = cmd.value;
			end else begin : g_mid
				assign cell_above[gi] = cell_data[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_bot
				assign cell_below[gi] = cell_data[gi];
			end else begin : g_up
				assign cell_below[gi] = cell_data[gi+1];
			end

			sls_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occupied  (count_q > CNT_W'(gi)),
				.key       (cmd.value),
				.new_value (cmd.new_value),
				.above     (cell_above[gi]),
				.below     (cell_below[gi]),
				.match_in  (match[gi]),
				.match_out (match[gi+1]),
				.first_hit (cell_hit1[gi]),
				.data      (cell_data[gi])
			);
		end
	endgenerate

	always_comb begin
		count_next              = count_q;
		result_next.status      = sls_pkg::ST_OK;
		result_next.data_out    = '0;
		result_next.top_value   = empty ? '0 : cell_data[0];
		case (cmd.kind)
			sls_pkg::OP_PUSH: begin
				if (full) begin
					result_next.status = sls_pkg::ST_FULL;
				end else begin
					count_next            = count_q + CNT_W'(1);
					result_next.top_value = cmd.value;
				end
			end
			sls_pkg::OP_POP: begin
				if (empty) begin
					result_next.status = sls_pkg::ST_EMPTY;
				end else begin
					count_next            = count_q - CNT_W'(1);
					result_next.data_out  = cell_data[0];
					result_next.top_value = (count_q > CNT_W'(1)) ? cell_below[0] : '0;
				end
			end
			sls_pkg::OP_SEARCH: begin
				if (empty) begin
					result_next.status = sls_pkg::ST_EMPTY;
				end else if (!found) begin
					result_next.status = sls_pkg::ST_MISSING;
				end
			end
			sls_pkg::OP_UPDATE: begin
				if (empty) begin
					result_next.status = sls_pkg::ST_EMPTY;
				end else if (!found) begin
					result_next.status = sls_pkg::ST_MISSING;
				end else if (cell_hit1[0]) begin
					result_next.top_value = cmd.new_value;
				end
			end
			default: begin
				result_next.status = sls_pkg::ST_OK;
			end
		endcase
		result_next.is_empty      = (count_next == '0);
		result_next.element_count = sls_pkg::COUNT_W'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= start;
			if (start) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			result_q <= result_next;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_strobe_follows: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start))
		else $error("result strobe without a command");

	a_push_top: assert property (@(posedge clk) disable iff (!arst_n)
		(start && cmd.kind == sls_pkg::OP_PUSH && !full) |=>
		(result.top_value == $past(cmd.value) && count_q == $past(count_q) + CNT_W'(1)))
		else $error("push did not land on top");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		(start && cmd.kind == sls_pkg::OP_POP && !empty) |=>
		(result.data_out == $past(cell_data[0]) && count_q == $past(count_q) - CNT_W'(1)))
		else $error("pop returned wrong word");

endmodule
